@@ sv/tlb_page_table_fifo_translator_top_macros.svh @@
// assertion macros for the tlb translator block
// used by the top level and the tlb module; no other dependencies
`ifndef TLB_PAGE_TABLE_FIFO_TRANSLATOR_TOP_MACROS_SVH
`define TLB_PAGE_TABLE_FIFO_TRANSLATOR_TOP_MACROS_SVH
`ifndef ASSERT_OFF
// checked after reset has been released
`define TPT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);
// checked during reset as well
`define TPT_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) \
		else $error(msg);
`else
`define TPT_ASSERT(lbl, prop, msg)
`define TPT_ASSERT_RST(lbl, prop, msg)
`endif
`endif

@@ sv/tlbpt_pkg.sv @@
// shared sizes, types and control structs of the tlb translator
// no dependencies; page, frame, tlb and page sizes are powers of two
`default_nettype none
package tlbpt_pkg;

	localparam int TLB_ENTRIES = 16;
	localparam int PAGE_COUNT  = 256;
	localparam int FRAME_COUNT = 128;
	localparam int PAGE_BYTES  = 256;

	localparam int TLB_IDX_W = $clog2(TLB_ENTRIES);
	localparam int PAGE_W    = $clog2(PAGE_COUNT);
	localparam int FRAME_W   = $clog2(FRAME_COUNT);
	localparam int OFF_W     = $clog2(PAGE_BYTES);

	// fixed payload widths
	localparam int LA_W = 16;
	localparam int PA_W = 15;
	localparam int FN_W = 7;
	localparam int ST_W = 2;
	localparam int EP_W = 8;

	typedef logic [PAGE_W-1:0]    page_t;
	typedef logic [FRAME_W-1:0]   frame_t;
	typedef logic [TLB_IDX_W-1:0] tlb_idx_t;
	typedef logic [OFF_W-1:0]     offset_t;

	typedef enum logic [ST_W-1:0] {
		ST_TLB_HIT   = 2'd0,
		ST_TABLE_HIT = 2'd1,
		ST_FAULT     = 2'd2
	} status_t;

	typedef enum logic {
		S_IDLE,
		S_LOOK
	} fsm_t;

	typedef struct packed {
		logic   fill;
		page_t  fill_page;
		frame_t fill_frame;
		logic   inval;
		page_t  inval_page;
	} tlb_req_t;

	typedef struct packed {
		logic   hit;
		frame_t frame;
	} tlb_rsp_t;

	typedef struct packed {
		logic  rd;
		page_t rd_page;
		logic  commit;
		page_t set_page;
		logic  evict;
		page_t evict_page;
	} tbl_req_t;

	typedef struct packed {
		logic   page_valid;
		frame_t page_frame;
		page_t  owner;
		frame_t next_frame;
		logic   memory_full;
	} tbl_rsp_t;

endpackage
`default_nettype wire

@@ sv/tlbpt_in_if.sv @@
// lookup channel: one logical address per beat
// depends on tlbpt_pkg
`default_nettype none
interface tlbpt_in_if;
	import tlbpt_pkg::*;

	logic            valid;
	logic            ready;
	logic [LA_W-1:0] logical_address;

	modport source (output valid, output logical_address, input ready);
	modport sink (input valid, input logical_address, output ready);
endinterface
`default_nettype wire

@@ sv/tlbpt_out_if.sv @@
// result channel: translated address, frame, status and eviction per beat
// depends on tlbpt_pkg
`default_nettype none
interface tlbpt_out_if;
	import tlbpt_pkg::*;

	logic            valid;
	logic            ready;
	logic [PA_W-1:0] physical_address;
	logic [FN_W-1:0] frame_number;
	logic [ST_W-1:0] status;
	logic            evicted_valid;
	logic [EP_W-1:0] evicted_page;

	modport source (output valid, output physical_address, output frame_number,
		output status, output evicted_valid, output evicted_page, input ready);
	modport sink (input valid, input physical_address, input frame_number,
		input status, input evicted_valid, input evicted_page, output ready);
endinterface
`default_nettype wire

@@ sv/tlbpt_table.sv @@
// page table and frame ownership memories with fifo frame allocator
// depends on tlbpt_pkg; memory reads are registered
`default_nettype none
module tlbpt_table (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire tlbpt_pkg::tbl_req_t req,
	output tlbpt_pkg::tbl_rsp_t      rsp
);
	import tlbpt_pkg::*;

	logic [PAGE_COUNT-1:0] pv_q;
	frame_t                frame_mem [PAGE_COUNT];
	page_t                 owner_mem [FRAME_COUNT];
	frame_t                next_q;
	logic                  full_q;
	logic                  pv_s1;
	frame_t                pframe_s1;
	page_t                 owner_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q   <= '0;
			next_q <= '0;
			full_q <= 1'b0;
		end else if (req.commit) begin
			if (req.evict)
				pv_q[req.evict_page] <= 1'b0;
			pv_q[req.set_page] <= 1'b1;
			if (next_q == FRAME_W'(FRAME_COUNT - 1)) begin
				next_q <= '0;
				full_q <= 1'b1;
			end else begin
				next_q <= next_q + 1'b1;
			end
		end
	end

	// memory write port
	always_ff @(posedge clk) begin
		if (req.commit) begin
			frame_mem[req.set_page] <= next_q;
			owner_mem[next_q]       <= req.set_page;
		end
	end

	// registered reads, issued in the accept cycle
	always_ff @(posedge clk) begin
		if (req.rd) begin
			pv_s1     <= pv_q[req.rd_page];
			pframe_s1 <= frame_mem[req.rd_page];
			owner_s1  <= owner_mem[next_q];
		end
	end

	assign rsp.page_valid  = pv_s1;
	assign rsp.page_frame  = pframe_s1;
	assign rsp.owner       = owner_s1;
	assign rsp.next_frame  = next_q;
	assign rsp.memory_full = full_q;
endmodule
`default_nettype wire

@@ sv/tlbpt_tlb.sv @@
// fully associative tlb with round-robin fill and invalidate by page
// depends on tlbpt_pkg and the assertion macro header
`default_nettype none
`include "tlb_page_table_fifo_translator_top_macros.svh"
module tlbpt_tlb (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire tlbpt_pkg::tlb_req_t req,
	input  wire tlbpt_pkg::page_t    lookup_page,
	output tlbpt_pkg::tlb_rsp_t      rsp
);
	import tlbpt_pkg::*;

	logic [TLB_ENTRIES-1:0] valid_q;
	page_t                  page_q  [TLB_ENTRIES];
	frame_t                 frame_q [TLB_ENTRIES];
	tlb_idx_t               ptr_q;
	tlb_idx_t               ptr_next;
	logic [TLB_ENTRIES-1:0] match;

	assign ptr_next = (ptr_q == TLB_IDX_W'(TLB_ENTRIES - 1)) ? '0 : ptr_q + 1'b1;

	always_comb begin
		rsp.frame = '0;
		for (int i = 0; i < TLB_ENTRIES; i++) begin
			match[i] = valid_q[i] && (page_q[i] == lookup_page);
			// entries never duplicate, so an or of the hits is the hit frame
			rsp.frame = rsp.frame | (match[i] ? frame_q[i] : '0);
		end
		rsp.hit = |match;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			ptr_q   <= '0;
		end else begin
			for (int i = 0; i < TLB_ENTRIES; i++) begin
				if (req.inval && valid_q[i] && (page_q[i] == req.inval_page))
					valid_q[i] <= 1'b0;
			end
			if (req.fill) begin
				valid_q[ptr_q] <= 1'b1;
				ptr_q          <= ptr_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.fill) begin
			page_q[ptr_q]  <= req.fill_page;
			frame_q[ptr_q] <= req.fill_frame;
		end
	end

	`TPT_ASSERT(a_tlb_no_dup, 1'b1 |-> $onehot0(match), "tlb holds a page twice")
	`TPT_ASSERT(a_tlb_fill_valid, req.fill |=> valid_q[$past(ptr_q)], "fill left entry invalid")
	`TPT_ASSERT(a_tlb_fill_ptr, req.fill |=> ptr_q == $past(ptr_next), "fill pointer did not step")
endmodule
`default_nettype wire

@@ sv/tlb_page_table_fifo_translator_top.sv @@
// An item is accepted in the idle state: in the accept cycle the page table
// and the page valid bits are read at the page of the address, and the frame
// owner memory at the next fifo frame; in the lookup state the tlb is searched,
// the answer is chosen and the tables are written back, and ready is low. A
// single output register holds the result; when it is still occupied the block
// waits in the lookup state until it is taken. Reset needs no clearing pass.
`default_nettype none
`include "tlb_page_table_fifo_translator_top_macros.svh"
module tlb_page_table_fifo_translator_top (
	input wire logic   clk,
	input wire logic   arst_n,
	tlbpt_in_if.sink   lookup,
	tlbpt_out_if.source result
);
	import tlbpt_pkg::*;

	fsm_t     state_q, state_d;
	tlb_req_t tlb_req;
	tlb_rsp_t tlb_rsp;
	tbl_req_t tbl_req;
	tbl_rsp_t tbl_rsp;

	page_t   page_s1;
	offset_t offset_s1;
	page_t   in_page;

	logic    accept, go, fault, evict;
	frame_t  frame;
	status_t status;
	page_t   ev_page;

	logic            out_valid_q;
	logic [PA_W-1:0] physical_address_q;
	logic [FN_W-1:0] frame_number_q;
	logic [ST_W-1:0] status_q;
	logic            evicted_valid_q;
	logic [EP_W-1:0] evicted_page_q;

	assign in_page = lookup.logical_address[OFF_W +: PAGE_W];

	tlbpt_tlb u_tlb (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (tlb_req),
		.lookup_page (page_s1),
		.rsp         (tlb_rsp)
	);

	tlbpt_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (tbl_req),
		.rsp    (tbl_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d      = state_q;
		lookup.ready = 1'b0;
		go           = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				lookup.ready = 1'b1;
				if (lookup.valid)
					state_d = S_LOOK;
			end
			S_LOOK: begin
				// resolve only once the output register can take the beat
				go = !out_valid_q || result.ready;
				if (go)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign accept = lookup.valid && lookup.ready;

	always_ff @(posedge clk) begin
		if (accept) begin
			page_s1   <= in_page;
			offset_s1 <= lookup.logical_address[OFF_W-1:0];
		end
	end

	always_comb begin
		fault = !tlb_rsp.hit && !tbl_rsp.page_valid;
		evict = fault && tbl_rsp.memory_full;
		if (tlb_rsp.hit) begin
			frame  = tlb_rsp.frame;
			status = ST_TLB_HIT;
		end else if (tbl_rsp.page_valid) begin
			frame  = tbl_rsp.page_frame;
			status = ST_TABLE_HIT;
		end else begin
			frame  = tbl_rsp.next_frame;
			status = ST_FAULT;
		end
		ev_page = evict ? tbl_rsp.owner : '0;

		tlb_req.fill       = go && !tlb_rsp.hit;
		tlb_req.fill_page  = page_s1;
		tlb_req.fill_frame = frame;
		tlb_req.inval      = go && evict;
		tlb_req.inval_page = tbl_rsp.owner;

		tbl_req.rd         = accept;
		tbl_req.rd_page    = in_page;
		tbl_req.commit     = go && fault;
		tbl_req.set_page   = page_s1;
		tbl_req.evict      = evict;
		tbl_req.evict_page = tbl_rsp.owner;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (go)
			out_valid_q <= 1'b1;
		else if (result.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (go) begin
			physical_address_q <= PA_W'({frame, offset_s1});
			frame_number_q     <= FN_W'(frame);
			status_q           <= ST_W'(status);
			evicted_valid_q    <= evict;
			evicted_page_q     <= EP_W'(ev_page);
		end
	end

	assign result.valid            = out_valid_q;
	assign result.physical_address = physical_address_q;
	assign result.frame_number     = frame_number_q;
	assign result.status           = status_q;
	assign result.evicted_valid    = evicted_valid_q;
	assign result.evicted_page     = evicted_page_q;

	`TPT_ASSERT(a_one_item, accept |=> !lookup.ready, "second beat taken during resolve")
	`TPT_ASSERT(a_tlb_in_table, (state_q == S_LOOK && tlb_rsp.hit) |-> tbl_rsp.page_valid, "stale tlb")
	`TPT_ASSERT(a_evict_full, (go && evict) |=> (out_valid_q && evicted_valid_q), "eviction not reported")
	`TPT_ASSERT_RST(a_reset_quiet, !arst_n |=> !result.valid, "result valid in reset")
endmodule
`default_nettype wire

@@ bench/tlb_page_table_fifo_translator_top_test.sv @@
// testbench for tlb_page_table_fifo_translator_top: drives logical addresses, predicts
// tlb hits, table hits, fifo faults and evictions, and checks every result beat
// depends on tlbpt_pkg, tlbpt_in_if, tlbpt_out_if and the top level
module tlb_page_table_fifo_translator_top_test;
	import tlbpt_pkg::*;

	localparam int STALL_LIMIT = 5000;

	typedef struct {
		logic [PA_W-1:0] physical_address;
		logic [FN_W-1:0] frame_number;
		status_t         status;
		logic            evicted_valid;
		logic [EP_W-1:0] evicted_page;
	} translation_t;

	class translation_scoreboard;
		logic         page_present[PAGE_COUNT];
		frame_t       page_to_frame[PAGE_COUNT];
		page_t        frame_to_page[FRAME_COUNT];
		logic         tlb_live[TLB_ENTRIES];
		page_t        tlb_tag[TLB_ENTRIES];
		frame_t       tlb_data[TLB_ENTRIES];
		tlb_idx_t     fill_ptr;
		frame_t       fifo_frame;
		logic         frames_used_up;
		translation_t expected_translations[$];
		int           errors;
		int           tlb_hit_count;
		int           table_hits;
		int           faults;
		int           evictions;

		function new();
			foreach (page_present[i]) page_present[i] = 1'b0;
			foreach (tlb_live[i]) tlb_live[i] = 1'b0;
			fill_ptr = '0;
			fifo_frame = '0;
			frames_used_up = 1'b0;
			errors = 0;
			tlb_hit_count = 0;
			table_hits = 0;
			faults = 0;
			evictions = 0;
		endfunction

		function void tlb_load(page_t pg, frame_t fr);
			tlb_live[fill_ptr] = 1'b1;
			tlb_tag[fill_ptr] = pg;
			tlb_data[fill_ptr] = fr;
			fill_ptr = fill_ptr + 1'b1;
		endfunction

		// work out the answer for an accepted address and update the tables
		function void note_address(logic [LA_W-1:0] addr);
			page_t        pg;
			offset_t      off;
			frame_t       fr;
			page_t        victim;
			int           hit_idx;
			translation_t t;
			pg = addr[OFF_W +: PAGE_W];
			off = addr[OFF_W-1:0];
			hit_idx = -1;
			t.evicted_valid = 1'b0;
			t.evicted_page = '0;
			for (int i = 0; i < TLB_ENTRIES; i++) begin
				if (hit_idx < 0 && tlb_live[i] && tlb_tag[i] == pg) hit_idx = i;
			end
			if (hit_idx >= 0) begin
				fr = tlb_data[hit_idx];
				t.status = ST_TLB_HIT;
				tlb_hit_count++;
			end else if (page_present[pg]) begin
				fr = page_to_frame[pg];
				t.status = ST_TABLE_HIT;
				table_hits++;
				tlb_load(pg, fr);
			end else begin
				fr = fifo_frame;
				t.status = ST_FAULT;
				faults++;
				if (frames_used_up) begin
					// the frame's old owner loses its mapping and any tlb copy
					victim = frame_to_page[fr];
					page_present[victim] = 1'b0;
					for (int i = 0; i < TLB_ENTRIES; i++) begin
						if (tlb_live[i] && tlb_tag[i] == victim) tlb_live[i] = 1'b0;
					end
					t.evicted_valid = 1'b1;
					t.evicted_page = victim;
					evictions++;
				end
				page_present[pg] = 1'b1;
				page_to_frame[pg] = fr;
				frame_to_page[fr] = pg;
				tlb_load(pg, fr);
				if (fr == frame_t'(FRAME_COUNT - 1)) begin
					fifo_frame = '0;
					frames_used_up = 1'b1;
				end else begin
					fifo_frame = fr + 1'b1;
				end
			end
			t.frame_number = fr;
			t.physical_address = PA_W'({fr, off});
			expected_translations.push_back(t);
		endfunction

		function void check_result(logic [PA_W-1:0] pa, logic [FN_W-1:0] fn,
				logic [ST_W-1:0] st, logic ev, logic [EP_W-1:0] ep);
			translation_t t;
			if (expected_translations.size() == 0) begin
				$display("%0t: result beat with nothing expected (pa %h)", $time, pa);
				errors++;
				return;
			end
			t = expected_translations.pop_front();
			if (pa !== t.physical_address) begin
				$display("%0t: physical_address expected %h got %h", $time,
					t.physical_address, pa);
				errors++;
			end
			if (fn !== t.frame_number) begin
				$display("%0t: frame_number expected %h got %h", $time, t.frame_number, fn);
				errors++;
			end
			if (st !== t.status) begin
				$display("%0t: status expected %0d got %0d", $time, t.status, st);
				errors++;
			end
			if (ev !== t.evicted_valid) begin
				$display("%0t: evicted_valid expected %b got %b", $time, t.evicted_valid, ev);
				errors++;
			end
			if (ep !== t.evicted_page) begin
				$display("%0t: evicted_page expected %h got %h", $time, t.evicted_page, ep);
				errors++;
			end
		endfunction

		function int pending();
			return expected_translations.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   send_idle_pct;
	int   recv_idle_pct;
	int   quiet_cycles;
	page_t recent_pages[$];

	translation_scoreboard sb = new();

	tlbpt_in_if  lookup_ch ();
	tlbpt_out_if result_ch ();

	tlb_page_table_fifo_translator_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.lookup (lookup_ch),
		.result (result_ch)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// receiver stalls
	always @(negedge clk) begin
		result_ch.ready = ($urandom_range(0, 99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready) begin
				sb.check_result(result_ch.physical_address, result_ch.frame_number,
					result_ch.status, result_ch.evicted_valid, result_ch.evicted_page);
			end
			if (lookup_ch.valid && lookup_ch.ready) sb.note_address(lookup_ch.logical_address);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((lookup_ch.valid && lookup_ch.ready) || (result_ch.valid && result_ch.ready)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
				$display("tb: failure");
				$finish;
			end
		end
	end

	// entered and left at a falling edge; one beat on the lookup channel
	task automatic send_address(input logic [LA_W-1:0] addr);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			lookup_ch.valid = 1'b0;
			lookup_ch.logical_address = LA_W'($urandom);
			@(negedge clk);
		end
		lookup_ch.valid = 1'b1;
		lookup_ch.logical_address = addr;
		@(posedge clk);
		while (!lookup_ch.ready) @(posedge clk);
		recent_pages.push_back(addr[OFF_W +: PAGE_W]);
		if (recent_pages.size() > TLB_ENTRIES) void'(recent_pages.pop_front());
		@(negedge clk);
	endtask

	initial begin
		page_t       pg;
		offset_t     off;
		int unsigned pick;
		arst_n = 1'b0;
		quiet_cycles = 0;
		send_idle_pct = 31;
		recv_idle_pct = 77;
		lookup_ch.valid = 1'b0;
		lookup_ch.logical_address = '0;
		result_ch.ready = 1'b0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		// field extremes, then a tlb hit on each of the first two pages
		send_address(16'h0000);
		send_address(16'hffff);
		send_address(16'h00ff);
		send_address(16'hff00);
		// sixteen more faults wrap the fill pointer over the first two entries
		for (int p = 1; p <= 16; p++) send_address({8'(p), 8'h5a ^ 8'(p)});
		// both pages are still mapped but gone from the tlb
		send_address(16'h0080);
		send_address(16'hffaa);
		send_address(16'h10a5);

		for (int n = 0; n < 1230; n++) begin
			if (n == 410) begin
				send_idle_pct = 77;
				recv_idle_pct = 31;
			end
			if (n == 820) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			pick = $urandom_range(0, 99);
			pg = page_t'($urandom);
			if (pick < 35 && recent_pages.size() > 0) begin
				// likely tlb hit
				pg = recent_pages[$urandom_range(0, recent_pages.size() - 1)];
			end else if (pick < 65) begin
				// look for a mapped page, likely a table hit
				for (int k = 0; k < 12 && !sb.page_present[pg]; k++) pg = page_t'($urandom);
			end
			case ($urandom_range(0, 7))
				0: off = '0;
				1: off = '1;
				default: off = offset_t'($urandom);
			endcase
			send_address({pg, off});
		end
		lookup_ch.valid = 1'b0;

		while (sb.pending() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		$display("%0d tlb hits, %0d table hits, %0d faults of which %0d evicted a page",
			sb.tlb_hit_count, sb.table_hits, sb.faults, sb.evictions);
		$display("random stalls on both channels, then back-to-back beats");
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
